/* design/pfr_pkg.sv */
package pfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 7;
    localparam int LEN_W     = 7;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;

    // frame bytes around the payload: header, id (interleaved only), checksum
    localparam int OVH_ID     = 3;
    localparam int OVH_LEGACY = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_INTERLEAVED = 3'd0;
    localparam t_cfg_idx CFG_HEADER      = 3'd1;
    localparam t_cfg_idx CFG_ID_IMU      = 3'd2;
    localparam t_cfg_idx CFG_ID_ORIENT   = 3'd3;
    localparam t_cfg_idx CFG_ID_NAV      = 3'd4;
    localparam t_cfg_idx CFG_LEN_IMU     = 3'd5;
    localparam t_cfg_idx CFG_LEN_ORIENT  = 3'd6;
    localparam t_cfg_idx CFG_LEN_NAV     = 3'd7;

    localparam logic              RST_INTERLEAVED = 1'b1;
    localparam logic [BYTE_W-1:0] RST_HEADER      = 8'd0;
    localparam logic [BYTE_W-1:0] RST_ID_IMU      = 8'd0;
    localparam logic [BYTE_W-1:0] RST_ID_ORIENT   = 8'd1;
    localparam logic [BYTE_W-1:0] RST_ID_NAV      = 8'd2;
    localparam logic [LEN_W-1:0]  RST_LEN_IMU     = 7'd36;
    localparam logic [LEN_W-1:0]  RST_LEN_ORIENT  = 7'd16;
    localparam logic [LEN_W-1:0]  RST_LEN_NAV     = 7'd69;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_ID      = 2'd1,
        PH_COLLECT = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_UNKNOWN  = 2'd0,
        KIND_INERTIAL = 2'd1,
        KIND_ORIENT   = 2'd2,
        KIND_NAV      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_VALID = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_PUSH_A,
        S_PUSH_B,
        S_PUSH_C,
        S_CK,
        S_CK_EVAL,
        S_RS_START,
        S_RS_SRCH,
        S_RS_MV0,
        S_RS_MOVE,
        S_RS_FIN,
        S_DONE
    } t_state;

    typedef enum logic {
        RET_PUSH,
        RET_ERR
    } t_ret;

    typedef enum logic [1:0] {
        WF_ZERO,
        WF_ONE,
        WF_POS
    } t_walk_from;

    typedef enum logic [1:0] {
        WM_CK,
        WM_SRCH,
        WM_MOVE
    } t_walk_mode;

    typedef struct packed {
        logic       in_ready;
        logic       rd_issue;
        logic       pre_clear;
        logic       clear;
        logic       push_apply;
        logic       walk_start;
        t_walk_from walk_from;
        logic       walk_step;
        t_walk_mode walk_mode;
        logic       rs_fin;
        logic       valid_inc;
        logic       err_inc;
        logic       out_load;
        t_status    out_status;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic full;
        logic fill_le1;
        logic id_bad;
        logic need_ck;
        logic walk_last;
        logic hit;
        logic ck_ok;
        logic out_free;
    } t_stat;

endpackage

/* design/pfr_if.sv */
interface pfr_in_if;
    import pfr_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, op, data_byte, read_index, input ready);
    modport sink   (input valid, op, data_byte, read_index, output ready);
endinterface

interface pfr_out_if;
    import pfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [1:0]        packet_kind;
    logic [BYTE_W-1:0] frame_length;
    logic [BYTE_W-1:0] read_data;
    logic [CNT_W-1:0]  valid_total;
    logic [CNT_W-1:0]  error_total;

    modport source (output valid, status, packet_kind, frame_length, read_data,
                    valid_total, error_total, input ready);
    modport sink   (input valid, status, packet_kind, frame_length, read_data,
                    valid_total, error_total, output ready);
endinterface

interface pfr_cfg_if;
    import pfr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/sensor_packet_framer_resync.sv */
// channel   role    payload
// i_in_ch   sink    op, data_byte, read_index
// o_out_ch  source  status, packet_kind, frame_length, read_data, valid_total, error_total
// i_cfg_ch  sink    index, data (always ready out of reset)
//
// a read goes through S_RD to the result; a plain push through S_PUSH_A, S_PUSH_B and S_PUSH_C
// a push that ends a frame adds a checksum walk over the buffer, the new byte included
// a resync adds a header search, then a tail move
// all walks go one byte per cycle through the buffer's single read port
// synchronous active-low reset; buffer contents are not cleared
// results wait in an output register while the sink stalls
module sensor_packet_framer_resync #(
    parameter int BUFFER_DEPTH = 128
) (
    input logic       i_clk,
    input logic       i_rst_n,
    pfr_in_if.sink    i_in_ch,
    pfr_out_if.source o_out_ch,
    pfr_cfg_if.sink   i_cfg_ch
);
    import pfr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    pfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    pfr_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .o_out_ch (o_out_ch),
        .i_cfg_ch (i_cfg_ch),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat)
    );

endmodule

/* design/pfr_ctrl.sv */
module pfr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pfr_pkg::t_stat i_stat,
    output pfr_pkg::t_cmd  o_cmd
);
    import pfr_pkg::*;

    t_state  r_state, n_state;
    t_ret    r_ret, n_ret;
    t_status r_status, n_status;
    t_state  ret_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= RET_PUSH;
            r_status <= ST_NONE;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_status <= n_status;
        end
    end

    assign ret_state = (r_ret == RET_PUSH) ? S_PUSH_C : S_DONE;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_status = ST_NONE;
                    n_state  = i_stat.in_op ? S_RD : S_PUSH_A;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_DONE;
            end
            S_PUSH_A: begin
                o_cmd.pre_clear = 1'b1;
                n_state         = S_PUSH_B;
            end
            S_PUSH_B: begin
                // full buffer: silent resync before the byte is taken
                if (i_stat.full) begin
                    n_ret   = RET_PUSH;
                    n_state = S_RS_START;
                end else begin
                    n_state = S_PUSH_C;
                end
            end
            S_PUSH_C: begin
                if (i_stat.full) begin
                    o_cmd.clear = 1'b1;
                end else begin
                    o_cmd.push_apply = 1'b1;
                    if (i_stat.id_bad) begin
                        o_cmd.err_inc = 1'b1;
                        n_ret         = RET_ERR;
                        n_status      = ST_ERROR;
                        n_state       = S_RS_START;
                    end else if (i_stat.need_ck) begin
                        o_cmd.walk_start = 1'b1;
                        o_cmd.walk_from  = WF_ZERO;
                        n_state          = S_CK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CK: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.walk_mode = WM_CK;
                if (i_stat.walk_last) begin
                    n_state = S_CK_EVAL;
                end
            end
            S_CK_EVAL: begin
                if (i_stat.ck_ok) begin
                    o_cmd.valid_inc = 1'b1;
                    n_status        = ST_VALID;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.err_inc = 1'b1;
                    n_ret         = RET_ERR;
                    n_status      = ST_ERROR;
                    n_state       = S_RS_START;
                end
            end
            S_RS_START: begin
                if (i_stat.fill_le1) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ret_state;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    o_cmd.walk_from  = WF_ONE;
                    n_state          = S_RS_SRCH;
                end
            end
            S_RS_SRCH: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.walk_mode = WM_SRCH;
                if (i_stat.hit) begin
                    n_state = S_RS_MV0;
                end else if (i_stat.walk_last) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ret_state;
                end
            end
            S_RS_MV0: begin
                o_cmd.walk_start = 1'b1;
                o_cmd.walk_from  = WF_POS;
                n_state          = S_RS_MOVE;
            end
            S_RS_MOVE: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.walk_mode = WM_MOVE;
                if (i_stat.walk_last) begin
                    n_state = S_RS_FIN;
                end
            end
            S_RS_FIN: begin
                o_cmd.rs_fin = 1'b1;
                n_state      = ret_state;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_status;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/pfr_dp.sv */
module pfr_dp #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfr_in_if.sink        i_in_ch,
    pfr_out_if.source     o_out_ch,
    pfr_cfg_if.sink       i_cfg_ch,
    input  pfr_pkg::t_cmd i_cmd,
    output pfr_pkg::t_stat o_stat
);
    import pfr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int TW = (FW > 8) ? FW : 8;
    localparam int CW = (FW > IDX_W) ? FW : IDX_W;

    function automatic t_kind kind_of_id(input logic [BYTE_W-1:0] id,
                                         input logic [BYTE_W-1:0] imu,
                                         input logic [BYTE_W-1:0] ori,
                                         input logic [BYTE_W-1:0] nav);
        t_kind k;
        if (id == imu) begin
            k = KIND_INERTIAL;
        end else if (id == ori) begin
            k = KIND_ORIENT;
        end else if (id == nav) begin
            k = KIND_NAV;
        end else begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

    function automatic logic [LEN_W-1:0] len_of_kind(input t_kind k,
                                                     input logic [LEN_W-1:0] li,
                                                     input logic [LEN_W-1:0] lo,
                                                     input logic [LEN_W-1:0] ln);
        logic [LEN_W-1:0] l;
        case (k)
            KIND_INERTIAL: l = li;
            KIND_ORIENT:   l = lo;
            KIND_NAV:      l = ln;
            default:       l = '0;
        endcase
        return l;
    endfunction

    // configuration
    logic              r_interleaved;
    logic [BYTE_W-1:0] r_header, r_id_imu, r_id_ori, r_id_nav;
    logic [LEN_W-1:0]  r_len_imu, r_len_ori, r_len_nav;

    // parser state
    t_phase           r_phase, n_phase;
    logic [FW-1:0]    r_fill, n_fill;
    logic [LEN_W-1:0] r_expected, n_expected;
    t_kind            r_kind, n_kind;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_valid_cnt, n_valid_cnt;
    logic [CNT_W-1:0] r_error_cnt, n_error_cnt;

    // latched input item
    logic              r_op;
    logic [BYTE_W-1:0] r_byte;
    logic [IDX_W-1:0]  r_idx;
    logic              r_rd_en;

    // buffer walk
    logic [FW-1:0]     r_wi, r_wtag, r_pos;
    logic              r_wv;
    logic [BYTE_W-1:0] r_x, r_id;
    logic              r_hdr_ok, r_ck_ok;

    // frame buffer
    logic [BYTE_W-1:0] r_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_q;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;

    // result register
    logic              r_out_valid;
    t_status           r_out_status;
    t_kind             r_out_kind;
    logic [BYTE_W-1:0] r_out_len, r_out_rd;
    logic [CNT_W-1:0]  r_out_vtot, r_out_etot;

    logic              in_xfer;
    logic              walk_last, hit, issue;
    t_kind             byte_kind, id_kind;
    logic [FW-1:0]     keep, mv_dst, wfrom;
    logic [TW-1:0]     total;
    logic [FW+7:0]     fill_ext;

    assign in_xfer = i_in_ch.valid && i_in_ch.ready;
    // nothing is taken while reset is held
    assign i_in_ch.ready  = i_cmd.in_ready && i_rst_n;
    assign i_cfg_ch.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interleaved <= RST_INTERLEAVED;
            r_header      <= RST_HEADER;
            r_id_imu      <= RST_ID_IMU;
            r_id_ori      <= RST_ID_ORIENT;
            r_id_nav      <= RST_ID_NAV;
            r_len_imu     <= RST_LEN_IMU;
            r_len_ori     <= RST_LEN_ORIENT;
            r_len_nav     <= RST_LEN_NAV;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.index)
                CFG_INTERLEAVED: r_interleaved <= i_cfg_ch.data[0];
                CFG_HEADER:      r_header      <= i_cfg_ch.data;
                CFG_ID_IMU:      r_id_imu      <= i_cfg_ch.data;
                CFG_ID_ORIENT:   r_id_ori      <= i_cfg_ch.data;
                CFG_ID_NAV:      r_id_nav      <= i_cfg_ch.data;
                CFG_LEN_IMU:     r_len_imu     <= i_cfg_ch.data[LEN_W-1:0];
                CFG_LEN_ORIENT:  r_len_ori     <= i_cfg_ch.data[LEN_W-1:0];
                CFG_LEN_NAV:     r_len_nav     <= i_cfg_ch.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= i_in_ch.op;
            r_byte <= i_in_ch.data_byte;
            r_idx  <= i_in_ch.read_index;
        end
        if (i_cmd.rd_issue) begin
            r_rd_en <= (CW'(r_idx) < CW'(r_fill));
        end
    end

    assign byte_kind = kind_of_id(r_byte, r_id_imu, r_id_ori, r_id_nav);
    assign id_kind   = kind_of_id(r_id, r_id_imu, r_id_ori, r_id_nav);
    assign keep      = r_fill - r_pos;
    assign mv_dst    = r_wtag - r_pos;
    assign total     = TW'(r_expected) + (r_interleaved ? TW'(OVH_ID) : TW'(OVH_LEGACY));
    assign fill_ext  = {8'd0, r_fill};

    assign walk_last = r_wv && (r_wtag == r_fill - FW'(1));
    assign hit       = i_cmd.walk_step && (i_cmd.walk_mode == WM_SRCH) && r_wv
                       && (r_q == r_header);
    assign issue     = i_cmd.walk_step && !i_cmd.walk_start && (r_wi < r_fill);

    always_comb begin
        case (i_cmd.walk_from)
            WF_ZERO: wfrom = '0;
            WF_ONE:  wfrom = FW'(1);
            default: wfrom = r_pos;
        endcase
    end

    // parser updates
    always_comb begin
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_expected  = r_expected;
        n_kind      = r_kind;
        n_done      = r_done;
        n_valid_cnt = r_valid_cnt;
        n_error_cnt = r_error_cnt;
        mem_we      = 1'b0;
        mem_waddr   = r_fill[AW-1:0];
        mem_wdata   = r_byte;

        if (i_cmd.clear || (i_cmd.pre_clear && r_done)) begin
            n_phase    = PH_HEADER;
            n_fill     = '0;
            n_expected = '0;
            n_kind     = KIND_UNKNOWN;
        end
        if (i_cmd.pre_clear) begin
            n_done = 1'b0;
        end

        if (i_cmd.push_apply) begin
            case (r_phase)
                PH_ID: begin
                    mem_we = 1'b1;
                    n_fill = r_fill + FW'(1);
                    if (byte_kind != KIND_UNKNOWN) begin
                        n_expected = len_of_kind(byte_kind, r_len_imu, r_len_ori, r_len_nav);
                        n_kind     = byte_kind;
                        n_phase    = PH_COLLECT;
                    end
                end
                PH_COLLECT: begin
                    mem_we = 1'b1;
                    n_fill = r_fill + FW'(1);
                end
                default: begin
                    if (r_byte == r_header) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        n_fill    = FW'(1);
                        if (r_interleaved) begin
                            n_phase = PH_ID;
                        end else begin
                            n_expected = r_len_imu;
                            n_kind     = KIND_INERTIAL;
                            n_phase    = PH_COLLECT;
                        end
                    end
                end
            endcase
        end

        // move step: tail byte goes down by the header offset
        if (i_cmd.walk_step && (i_cmd.walk_mode == WM_MOVE) && r_wv) begin
            mem_we    = 1'b1;
            mem_waddr = mv_dst[AW-1:0];
            mem_wdata = r_q;
        end

        if (i_cmd.rs_fin) begin
            n_fill = keep;
            if (r_interleaved) begin
                if (keep >= FW'(2)) begin
                    if (id_kind == KIND_UNKNOWN) begin
                        n_phase    = PH_HEADER;
                        n_fill     = '0;
                        n_expected = '0;
                        n_kind     = KIND_UNKNOWN;
                    end else begin
                        n_expected = len_of_kind(id_kind, r_len_imu, r_len_ori, r_len_nav);
                        n_kind     = id_kind;
                        n_phase    = PH_COLLECT;
                    end
                end else begin
                    n_phase = PH_ID;
                end
            end else begin
                n_expected = r_len_imu;
                n_kind     = KIND_INERTIAL;
                n_phase    = PH_COLLECT;
            end
        end

        if (i_cmd.valid_inc) begin
            n_valid_cnt = r_valid_cnt + CNT_W'(1);
            n_done      = 1'b1;
        end
        if (i_cmd.err_inc) begin
            n_error_cnt = r_error_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_fill      <= '0;
            r_expected  <= '0;
            r_kind      <= KIND_UNKNOWN;
            r_done      <= 1'b0;
            r_valid_cnt <= '0;
            r_error_cnt <= '0;
        end else begin
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_expected  <= n_expected;
            r_kind      <= n_kind;
            r_done      <= n_done;
            r_valid_cnt <= n_valid_cnt;
            r_error_cnt <= n_error_cnt;
        end
    end

    // walk engine: one buffer read issued per step, consumed in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
        end else if (i_cmd.walk_start) begin
            r_wi     <= wfrom;
            r_wv     <= 1'b0;
            r_x      <= '0;
            r_hdr_ok <= 1'b0;
        end else if (i_cmd.walk_step) begin
            r_wv <= issue;
            if (issue) begin
                r_wtag <= r_wi;
                r_wi   <= r_wi + FW'(1);
            end
            if (r_wv) begin
                case (i_cmd.walk_mode)
                    WM_CK: begin
                        if (r_wtag == '0) begin
                            r_hdr_ok <= (r_q == r_header);
                        end else if (!walk_last) begin
                            r_x <= r_x ^ r_q;
                        end
                        if (walk_last) begin
                            r_ck_ok <= (r_fill >= FW'(2)) && r_hdr_ok && (r_x == r_q);
                        end
                    end
                    WM_SRCH: begin
                        if (hit) begin
                            r_pos <= r_wtag;
                        end
                    end
                    default: begin
                        if (r_wtag == r_pos + FW'(1)) begin
                            r_id <= r_q;
                        end
                    end
                endcase
            end
        end
    end

    assign rd_en   = issue || i_cmd.rd_issue;
    assign rd_addr = i_cmd.rd_issue ? AW'(r_idx) : r_wi[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_q <= r_mem[rd_addr];
        end
    end

    // result register, frees the controller while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_kind   <= r_kind;
            r_out_len    <= fill_ext[7:0];
            r_out_rd     <= (r_op && r_rd_en) ? r_q : '0;
            r_out_vtot   <= r_valid_cnt;
            r_out_etot   <= r_error_cnt;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.status       = r_out_status;
    assign o_out_ch.packet_kind  = r_out_kind;
    assign o_out_ch.frame_length = r_out_len;
    assign o_out_ch.read_data    = r_out_rd;
    assign o_out_ch.valid_total  = r_out_vtot;
    assign o_out_ch.error_total  = r_out_etot;

    always_comb begin
        o_stat.in_valid  = i_in_ch.valid;
        o_stat.in_op     = i_in_ch.op;
        o_stat.full      = (r_fill >= FW'(BUFFER_DEPTH));
        o_stat.fill_le1  = (r_fill <= FW'(1));
        o_stat.id_bad    = (r_phase == PH_ID) && (byte_kind == KIND_UNKNOWN);
        o_stat.need_ck   = (r_phase == PH_COLLECT) && ((TW'(r_fill) + TW'(1)) >= total);
        o_stat.walk_last = walk_last;
        o_stat.hit       = hit;
        o_stat.ck_ok     = r_ck_ok;
        o_stat.out_free  = !r_out_valid || o_out_ch.ready;
    end

endmodule
